// ===== rtl/p2rgba_pkg.sv =====
package p2rgba_pkg;

  localparam int NUM_PALETTES    = 16;
  localparam int PALETTE_ENTRIES = 256;
  localparam int SEL_W           = 4;
  localparam int IDX_W           = 8;
  localparam int WORD_W          = 16;
  localparam int ADDR_W          = SEL_W + IDX_W;
  localparam int RAM_DEPTH       = NUM_PALETTES * PALETTE_ENTRIES;
  localparam int COUNT_W         = 5;
  localparam int S_TDATA_W       = 32;
  localparam int M_TDATA_W       = 32;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 16;

  localparam int SCALE_SHIFT = 20;
  localparam logic [27:0] SCALE5_MUL = 28'(255 * ((1 << SCALE_SHIFT) / 31 + 1));
  localparam logic [27:0] SCALE6_MUL = 28'(255 * ((1 << SCALE_SHIFT) / 63 + 1));

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_INDEXED = 2'd1,
    OP_DIRECT  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PALETTES_IN_USE = 1'b0,
    REG_COLORKEY_MASK   = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_ZERO   = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DIRECT = 2'd2
  } mode_t;

  function automatic logic [7:0] scale5(input logic [4:0] c);
    logic [27:0] p;
    p = 28'(c) * SCALE5_MUL;
    return p[27:20];
  endfunction

  function automatic logic [7:0] scale6(input logic [5:0] c);
    logic [27:0] p;
    p = 28'(c) * SCALE6_MUL;
    return p[27:20];
  endfunction

  function automatic logic [31:0] conv555(input logic [WORD_W-1:0] w);
    return {8'hFF, scale5(w[14:10]), scale5(w[9:5]), scale5(w[4:0])};
  endfunction

  function automatic logic [31:0] conv565(input logic [WORD_W-1:0] w);
    return {8'hFF, scale5(w[4:0]), scale6(w[10:5]), scale5(w[15:11])};
  endfunction

endpackage

// ===== rtl/p2rgba_ram.sv =====
module p2rgba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/palette_pixel_to_rgba_converter.sv =====
// Channel  Direction  Payload
// s_       in         tdata: op, palette_sel, color_index, word_value
// m_       out        tdata: rgba; tuser: palette_rejected
// cfg_     in         write enable, register index, data
// One item is accepted per cycle unless a stalled output holds stage 1.
// The palette RAM read is registered in stage 1, then the color scaling is registered.
// Palette writes take effect at once, so a following lookup sees them.
// Reset clears the registers and the pipeline, not the palette RAM.
// A stalled output holds its stage and the RAM read data until it moves.
module palette_pixel_to_rgba_converter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // op, palette_sel, color_index, word_value, zero fill
  input  logic [p2rgba_pkg::S_TDATA_W-1:0]      s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // rgba
  output logic [p2rgba_pkg::M_TDATA_W-1:0]      m_tdata,
  // palette_rejected
  output logic                                  m_tuser,
  input  logic                                  cfg_we,
  input  logic [p2rgba_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [p2rgba_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import p2rgba_pkg::*;

  logic [COUNT_W-1:0] palettes_in_use;
  logic [NUM_PALETTES-1:0] colorkey_mask;

  op_t               in_op;
  logic [SEL_W-1:0]  in_sel;
  logic [IDX_W-1:0]  in_idx;
  logic [WORD_W-1:0] in_word;
  logic              accept;
  logic              ram_we;
  logic              ram_re;
  logic [WORD_W-1:0] ram_q;

  logic [WORD_W-1:0] entry0 [NUM_PALETTES];

  logic              s1_valid;
  logic              s1_go;
  mode_t             s1_mode;
  mode_t             s1_mode_next;
  logic              s1_rej;
  logic              s1_rej_next;
  logic [WORD_W-1:0] s1_word;
  logic [WORD_W-1:0] s1_entry0;
  logic [WORD_W-1:0] pick;
  logic [31:0]       rgba_next;

  assign in_op   = op_t'(s_tdata[1:0]);
  assign in_sel  = s_tdata[5:2];
  assign in_idx  = s_tdata[13:6];
  assign in_word = s_tdata[29:14];

  assign accept = s_tvalid && s_tready;
  assign ram_we = accept && (in_op == OP_WRITE);
  assign ram_re = accept && (in_op == OP_INDEXED);

  always_ff @(posedge clk) begin
    if (rst) begin
      palettes_in_use <= '0;
      colorkey_mask   <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_PALETTES_IN_USE: palettes_in_use <= cfg_data[COUNT_W-1:0];
        REG_COLORKEY_MASK:   colorkey_mask   <= cfg_data[NUM_PALETTES-1:0];
      endcase
    end
  end

  p2rgba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({in_sel, in_idx}),
    .wdata (in_word),
    .re    (ram_re),
    .raddr ({in_sel, in_idx}),
    .rdata (ram_q)
  );

  // Entry 0 of each palette is mirrored so that a zero word can fall back to it.
  always_ff @(posedge clk) begin
    if (ram_we && (in_idx == '0)) begin
      entry0[in_sel] <= in_word;
    end
  end

  always_comb begin
    s1_rej_next  = 1'b0;
    s1_mode_next = MODE_ZERO;
    if (in_op == OP_INDEXED) begin
      if ({1'b0, in_sel} >= palettes_in_use) begin
        s1_rej_next = 1'b1;
      end else if (!(colorkey_mask[in_sel] && (in_idx == '0))) begin
        s1_mode_next = MODE_LOOKUP;
      end
    end else if (in_word != '0) begin
      s1_mode_next = MODE_DIRECT;
    end
  end

  assign s1_go    = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= accept && ((in_op == OP_INDEXED) || (in_op == OP_DIRECT));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode   <= s1_mode_next;
      s1_rej    <= s1_rej_next;
      s1_word   <= in_word;
      s1_entry0 <= entry0[in_sel];
    end
  end

  assign pick = (ram_q == '0) ? s1_entry0 : ram_q;

  always_comb begin
    unique case (s1_mode)
      MODE_LOOKUP: rgba_next = conv555(pick);
      MODE_DIRECT: rgba_next = conv565(s1_word);
      MODE_ZERO:   rgba_next = '0;
      default:     rgba_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid) begin
      m_tdata <= rgba_next;
      m_tuser <= s1_rej;
    end
  end

endmodule

// ===== rtl/p2rgba_checker.sv =====
module p2rgba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Output item changed while stalled.");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("Rejected item carries a nonzero color.");

  a_alpha_opaque: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata != 32'd0) |-> m_tdata[31:24] == 8'hFF && !m_tuser)
    else $error("Nonzero color without full alpha.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output valid right after reset.");

endmodule

bind palette_pixel_to_rgba_converter p2rgba_checker u_p2rgba_checker (.*);

// ===== dv/palette_pixel_to_rgba_converter_tb.sv =====
module palette_pixel_to_rgba_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import p2rgba_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct {
    op_t               op;
    logic [SEL_W-1:0]  sel;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
  } pixel_item_t;

  typedef struct {
    logic [31:0] rgba;
    logic        rejected;
  } rgba_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tuser;
  logic                   cfg_we = 1'b0;
  reg_index_t             cfg_index = REG_PALETTES_IN_USE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  pixel_item_t  pending_pixels[$];
  rgba_result_t expected_rgba[$];
  pixel_item_t  in_flight;

  // Predictor state.
  logic [COUNT_W-1:0] palette_count = '0;
  logic [15:0]        key_mask = '0;
  logic [WORD_W-1:0]  palette_mem [RAM_DEPTH];

  // Stimulus-side view of which palette entries hold data.
  logic [WORD_W-1:0]  gen_mem [RAM_DEPTH];
  bit                 gen_known [RAM_DEPTH];

  int gap_left = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_span = 0;
  int cycle_count = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_lookups = 0;
  int n_direct = 0;
  int n_ignored = 0;
  int n_rejected = 0;
  int n_transparent = 0;
  int n_settings = 0;

  palette_pixel_to_rgba_converter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int unsigned active_palettes();
    return (palette_count > NUM_PALETTES) ? NUM_PALETTES : palette_count;
  endfunction

  function automatic logic [7:0] chan_scale(input int unsigned c, input int unsigned full);
    int unsigned q;
    q = (c * 255) / full;
    return q[7:0];
  endfunction

  function automatic void predict_pixel(input pixel_item_t it);
    rgba_result_t r;
    logic [WORD_W-1:0] w;
    r.rgba = '0;
    r.rejected = 1'b0;
    case (it.op)
      OP_WRITE: begin
        palette_mem[{it.sel, it.idx}] = it.word;
        n_writes++;
      end
      OP_INDEXED: begin
        n_lookups++;
        if (it.sel >= active_palettes()) begin
          r.rejected = 1'b1;
          n_rejected++;
        end else if (key_mask[it.sel] && it.idx == 0) begin
          n_transparent++;
        end else begin
          w = palette_mem[{it.sel, it.idx}];
          if (w == 0) w = palette_mem[{it.sel, 8'd0}];
          r.rgba = {8'hFF, chan_scale(w[14:10], 31), chan_scale(w[9:5], 31),
                    chan_scale(w[4:0], 31)};
        end
        expected_rgba.push_back(r);
      end
      OP_DIRECT: begin
        n_direct++;
        if (it.word != 0) begin
          r.rgba = {8'hFF, chan_scale(it.word[4:0], 31), chan_scale(it.word[10:5], 63),
                    chan_scale(it.word[15:11], 31)};
        end
        expected_rgba.push_back(r);
      end
      default: n_ignored++;
    endcase
  endfunction

  // A lookup is only issued when it cannot touch an entry that was never written.
  function automatic bit lookup_ok(input logic [SEL_W-1:0] sel, input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] a;
    a = {sel, idx};
    if (sel >= active_palettes()) return 1'b1;
    if (key_mask[sel] && idx == 0) return 1'b1;
    if (!gen_known[a]) return 1'b0;
    return gen_mem[a] != 0 || gen_known[{sel, 8'd0}];
  endfunction

  function automatic void queue_item(input op_t op, input logic [SEL_W-1:0] sel,
                                     input logic [IDX_W-1:0] idx,
                                     input logic [WORD_W-1:0] word);
    pixel_item_t it;
    it.op = op;
    it.sel = sel;
    it.idx = idx;
    it.word = word;
    if (op == OP_WRITE) begin
      gen_mem[{sel, idx}] = word;
      gen_known[{sel, idx}] = 1'b1;
    end
    pending_pixels.push_back(it);
  endfunction

  task automatic push_random_items(input int n);
    int unsigned pick;
    int unsigned lim;
    int tries;
    logic [SEL_W-1:0] sel;
    logic [IDX_W-1:0] idx;
    logic [WORD_W-1:0] word;
    lim = active_palettes();
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      word = 16'($urandom);
      case ($urandom_range(0, 9))
        0: word = '0;
        1: word = '1;
        default: ;
      endcase
      sel = 4'($urandom_range(0, 15));
      if (lim != 0 && $urandom_range(0, 7) != 0) sel = 4'($urandom_range(0, lim - 1));
      idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15));
      if (pick < 30) begin
        queue_item(OP_WRITE, sel, idx, word);
      end else if (pick < 75) begin
        tries = 0;
        while (!lookup_ok(sel, idx) && tries < 16) begin
          idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 15));
          tries++;
        end
        if (lookup_ok(sel, idx)) queue_item(OP_INDEXED, sel, idx, word);
        else queue_item(OP_WRITE, sel, idx, word);
      end else if (pick < 95) begin
        queue_item(OP_DIRECT, sel, idx, word);
      end else begin
        queue_item(OP_NONE, sel, idx, word);
      end
    end
  endtask

  task automatic set_register(input reg_index_t r, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    if (r == REG_PALETTES_IN_USE) palette_count = v[COUNT_W-1:0];
    else key_mask = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Palette writes and unused ops give no result, so the task keeps waiting after the queues drain to let the
  // pipeline empty before any register changes.
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || s_tvalid || expected_rgba.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) predict_pixel(in_flight);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        in_flight = pending_pixels.pop_front();
        s_tdata <= {2'b00, in_flight.word, in_flight.idx, in_flight.sel, in_flight.op};
        s_tvalid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(16, 160);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    rgba_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rgba.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected item rgba %h rejected %b", $time, m_tdata, m_tuser);
      end else begin
        want = expected_rgba.pop_front();
        n_checked++;
        if (m_tdata !== want.rgba) begin
          n_errors++;
          $display("%0t: rgba expected %h actual %h", $time, want.rgba, m_tdata);
        end
        if (m_tuser !== want.rejected) begin
          n_errors++;
          $display("%0t: palette_rejected expected %b actual %b", $time, want.rejected,
                   m_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_rgba.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned counts [RANDOM_PHASES];
    logic [15:0] masks [RANDOM_PHASES];
    counts = '{16, 31, 1, 0, 8, 16, 17, 5};
    masks = '{16'hFFFF, 16'h0000, 16'h0001, 16'hA5A5, 16'h00FF, 16'h5A5A, 16'h8000, 16'h0000};
    counts[RANDOM_PHASES - 1] = $urandom_range(0, 31);
    masks[RANDOM_PHASES - 1] = 16'($urandom);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Registers at their reset values: every lookup is rejected.
    queue_item(OP_WRITE, 4'd0, 8'd0, 16'h7FFF);
    queue_item(OP_INDEXED, 4'd0, 8'd0, 16'h0000);
    queue_item(OP_DIRECT, 4'd0, 8'd0, 16'hFFFF);
    n_settings++;
    wait_idle();

    set_register(REG_PALETTES_IN_USE, 16'd16);
    set_register(REG_COLORKEY_MASK, 16'h8001);
    n_settings++;
    queue_item(OP_WRITE, 4'd0, 8'd1, 16'h0000);
    queue_item(OP_WRITE, 4'd0, 8'd2, 16'h801F);
    queue_item(OP_WRITE, 4'd15, 8'd255, 16'h03E0);
    queue_item(OP_WRITE, 4'd15, 8'd0, 16'h7C00);
    queue_item(OP_WRITE, 4'd1, 8'd0, 16'h0000);
    queue_item(OP_WRITE, 4'd1, 8'd128, 16'h5555);
    queue_item(OP_WRITE, 4'd7, 8'd170, 16'h2AAA);
    queue_item(OP_INDEXED, 4'd0, 8'd0, 16'h0000);
    queue_item(OP_INDEXED, 4'd0, 8'd1, 16'h0000);
    queue_item(OP_INDEXED, 4'd0, 8'd2, 16'h0000);
    queue_item(OP_INDEXED, 4'd15, 8'd255, 16'h0000);
    queue_item(OP_INDEXED, 4'd15, 8'd0, 16'h0000);
    queue_item(OP_INDEXED, 4'd1, 8'd0, 16'h0000);
    queue_item(OP_INDEXED, 4'd1, 8'd128, 16'h0000);
    queue_item(OP_INDEXED, 4'd7, 8'd170, 16'h0000);
    queue_item(OP_DIRECT, 4'd0, 8'd0, 16'h0000);
    queue_item(OP_DIRECT, 4'd0, 8'd0, 16'hFFFF);
    queue_item(OP_DIRECT, 4'd0, 8'd0, 16'hF800);
    queue_item(OP_DIRECT, 4'd0, 8'd0, 16'h07E0);
    queue_item(OP_DIRECT, 4'd0, 8'd0, 16'h001F);
    queue_item(OP_DIRECT, 4'd0, 8'd0, 16'h0821);
    queue_item(OP_NONE, 4'd15, 8'd255, 16'hFFFF);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_register(REG_PALETTES_IN_USE, 16'(counts[p]));
      set_register(REG_COLORKEY_MASK, masks[p]);
      n_settings++;
      push_random_items(ITEMS_PER_PHASE);
      wait_idle();
    end

    $display("Sent %0d palette writes, %0d lookups, %0d direct pixels, %0d unused ops",
             n_writes, n_lookups, n_direct, n_ignored);
    $display("under %0d register settings; %0d results checked, %0d rejected, %0d keyed.",
             n_settings, n_checked, n_rejected, n_transparent);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
